@@ design/prime_gap_tracker_unit_defines.svh @@
// Assertion macros for the prime gap tracker.
// Included by pgt_ctrl, the module that carries concurrent checks; no other dependencies.
`ifndef PRIME_GAP_TRACKER_UNIT_DEFINES_SVH
`define PRIME_GAP_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PGT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PGT_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PGT_ASSERT(lbl, clk, rstn, prop, msg)
`define PGT_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

@@ design/pgt_pkg.sv @@
// Shared constants and controller/datapath types for the prime gap tracker.
// No dependencies.
package pgt_pkg;

  localparam int unsigned FIELD_W         = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_div;
    logic finish;
    logic prime;
  } pgt_cmd_t;

  typedef struct packed {
    logic small_val;
    logic sq_gt;
    logic div_last;
    logic rem_zero;
  } pgt_sts_t;

endpackage

@@ design/pgt_in_if.sv @@
// Input channel: candidate word with valid/ready handshake.
// Depends on pgt_pkg for the field width.
interface pgt_in_if;
  logic                         valid;
  logic                         ready;
  logic [pgt_pkg::FIELD_W-1:0]  value;
  logic                         new_range;

  modport source (output valid, output value, output new_range, input ready);
  modport sink   (input valid, input value, input new_range, output ready);
endinterface

@@ design/pgt_out_if.sv @@
// Result channel: primality flag and gap tracking word with valid/ready handshake.
// Depends on pgt_pkg for the field width.
interface pgt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         prime_flag;
  logic [pgt_pkg::FIELD_W-1:0]  gap_from_previous;
  logic [pgt_pkg::FIELD_W-1:0]  largest_gap;
  logic [pgt_pkg::FIELD_W-1:0]  largest_gap_start;

  modport source (output valid, output prime_flag, output gap_from_previous,
                  output largest_gap, output largest_gap_start, input ready);
  modport sink   (input valid, input prime_flag, input gap_from_previous,
                  input largest_gap, input largest_gap_start, output ready);
endinterface

@@ design/prime_gap_tracker_unit.sv @@
// Top level of the prime gap tracker: trial-division primality test with
// largest-gap tracking. Depends on pgt_pkg, pgt_in_if, pgt_out_if, pgt_ctrl, pgt_datapath.
//
//   channel  dir  handshake          word
//   in_i     in   valid/ready        value, new_range
//   out_o    out  valid/ready        prime_flag, gap_from_previous, largest_gap,
//                                    largest_gap_start
//
// Each trial divisor takes one bound check against the running divisor square,
// VALUE_WIDTH steps of the one-bit remainder unit and one test. A prime tries
// k = floor(sqrt(value))-1 divisors; a composite tries p-1, p its smallest factor.
// One item in work at a time; a word not yet taken holds the finish.
// Reset is asynchronous, active low, and clears tracking.
module prime_gap_tracker_unit #(
  parameter int unsigned VALUE_WIDTH = pgt_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pgt_in_if.sink      in_i,
  pgt_out_if.source   out_o
);

  pgt_pkg::pgt_cmd_t cmd;
  pgt_pkg::pgt_sts_t sts;

  pgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pgt_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .value_i             (in_i.value),
    .new_range_i         (in_i.new_range),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .prime_flag_o        (out_o.prime_flag),
    .gap_from_previous_o (out_o.gap_from_previous),
    .largest_gap_o       (out_o.largest_gap),
    .largest_gap_start_o (out_o.largest_gap_start)
  );

endmodule

@@ design/pgt_ctrl.sv @@
// Sequencer for trial division: steps divisors, runs the bit-serial remainder,
// hands results to the output register. Depends on pgt_pkg and the defines header.
`include "prime_gap_tracker_unit_defines.svh"

module pgt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pgt_pkg::pgt_sts_t sts_i,
  output pgt_pkg::pgt_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   prime_q, prime_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    prime_d = prime_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.small_val) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (sts_i.sq_gt) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_TEST;
      end
      ST_TEST: begin
        if (sts_i.rem_zero) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_DONE: begin
        cmd_o.prime = prime_q;
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prime_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prime_q     <= prime_d;
      out_valid_q <= out_valid_d;
    end
  end

  `PGT_ASSERT(a_one_at_a_time, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "second word accepted while busy")
  `PGT_ASSERT(a_finish_free, clk_i, rst_ni, cmd_o.finish |-> (!out_valid_q || out_ready_i), "result overwrote a pending word")
  `PGT_ASSERT(a_valid_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_o.finish), "output valid without a finished item")
  `PGT_ASSERT(a_div_end, clk_i, rst_ni, (state_q == ST_DIV && sts_i.div_last) |=> (state_q == ST_TEST), "remainder pass did not end in test")

endmodule

@@ design/pgt_datapath.sv @@
// Datapath: candidate, divisor and its square, bit-serial remainder unit,
// gap tracking state and output register. Depends on pgt_pkg.
module pgt_datapath #(
  parameter int unsigned VALUE_WIDTH = pgt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [pgt_pkg::FIELD_W-1:0]  value_i,
  input  logic                         new_range_i,
  input  pgt_pkg::pgt_cmd_t            cmd_i,
  output pgt_pkg::pgt_sts_t            sts_o,
  output logic                         prime_flag_o,
  output logic [pgt_pkg::FIELD_W-1:0]  gap_from_previous_o,
  output logic [pgt_pkg::FIELD_W-1:0]  largest_gap_o,
  output logic [pgt_pkg::FIELD_W-1:0]  largest_gap_start_o
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned FW    = pgt_pkg::FIELD_W;
  localparam int unsigned CNT_W = $clog2(W);
  localparam int unsigned SQ_W  = W + 2;

  logic [W-1:0]     v_q, d_q, r_q, shv_q;
  logic [SQ_W-1:0]  sq_q;
  logic [CNT_W-1:0] cnt_q;

  logic [W-1:0]     last_q, best_q, start_q;
  logic             have_q;

  logic             out_prime_q;
  logic [FW-1:0]    out_gap_q, out_best_q, out_start_q;

  logic [W:0]       trial;
  logic [W:0]       trial_sub;
  logic [W-1:0]     rem_next;
  logic [W-1:0]     gap;
  logic [W-1:0]     best_d, start_d;

  // one restoring-division bit per step
  assign trial     = {r_q, shv_q[W-1]};
  assign trial_sub = trial - {1'b0, d_q};
  assign rem_next  = trial_sub[W] ? trial[W-1:0] : trial_sub[W-1:0];

  assign sts_o.small_val = (v_q <= W'(1));
  assign sts_o.sq_gt     = (sq_q > {2'b00, v_q});
  assign sts_o.div_last  = (cnt_q == '0);
  assign sts_o.rem_zero  = (r_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q  <= W'(value_i);
      d_q  <= W'(2);
      sq_q <= SQ_W'(4);
    end else if (cmd_i.next_div) begin
      d_q  <= d_q + W'(1);
      sq_q <= sq_q + {1'b0, d_q, 1'b1};
    end
    if (cmd_i.div_start) begin
      r_q   <= '0;
      shv_q <= v_q;
      cnt_q <= CNT_W'(W - 1);
    end else if (cmd_i.div_step) begin
      r_q   <= rem_next;
      shv_q <= {shv_q[W-2:0], 1'b0};
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    gap     = '0;
    best_d  = best_q;
    start_d = start_q;
    if (cmd_i.prime && have_q) begin
      if (v_q > last_q) begin
        gap = v_q - last_q;
        if (gap > best_q) begin
          best_d  = gap;
          start_d = last_q;
        end
      end else begin
        best_d  = '0;
        start_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      have_q  <= 1'b0;
      best_q  <= '0;
      start_q <= '0;
    end else if (cmd_i.load && new_range_i) begin
      last_q  <= '0;
      have_q  <= 1'b0;
      best_q  <= '0;
      start_q <= '0;
    end else if (cmd_i.finish && cmd_i.prime) begin
      last_q  <= v_q;
      have_q  <= 1'b1;
      best_q  <= best_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_prime_q <= cmd_i.prime;
      out_gap_q   <= FW'(gap);
      out_best_q  <= FW'(best_d);
      out_start_q <= FW'(start_d);
    end
  end

  assign prime_flag_o        = out_prime_q;
  assign gap_from_previous_o = out_gap_q;
  assign largest_gap_o       = out_best_q;
  assign largest_gap_start_o = out_start_q;

endmodule
